// ===== sv/cc20_pkg.sv =====
// ---------------------------------------------------------------------------
// cc20_pkg
// Types, constants and round functions shared by the stream cipher core
// ---------------------------------------------------------------------------
`default_nettype none

package cc20_pkg;

  localparam int unsigned DataW      = 64;
  localparam int unsigned CountW     = 4;
  localparam int unsigned CfgIdxW    = 3;
  localparam int unsigned CfgDataW   = 64;
  localparam int unsigned NumLanes   = 8;
  localparam int unsigned BlockBytes = 64;
  localparam int unsigned OffsetW    = 7;
  localparam int unsigned StepW      = 6;
  localparam int unsigned DoubleRounds = 10;
  localparam int unsigned LastStep   = 4 * DoubleRounds - 1;

  localparam logic [31:0] Sigma [4] = '{
    32'h61707865, 32'h3320646e, 32'h79622d32, 32'h6b206574
  };

  typedef enum logic [CfgIdxW-1:0] {
    CFG_KEY_PART0     = 3'd0,
    CFG_KEY_PART1     = 3'd1,
    CFG_KEY_PART2     = 3'd2,
    CFG_KEY_PART3     = 3'd3,
    CFG_NONCE_LOW     = 3'd4,
    CFG_NONCE_HIGH    = 3'd5,
    CFG_START_COUNTER = 3'd6
  } cfg_reg_e;

  typedef struct packed {
    logic accept;
    logic chunk;
    logic gen_start;
    logic gen_step;
    logic gen_finish;
    logic load_out;
  } dp_cmd_t;

  typedef struct packed {
    logic all_done;
    logic buf_empty;
    logic last_step;
  } dp_sts_t;

  typedef struct packed {
    logic [31:0] a;
    logic [31:0] b;
    logic [31:0] c;
    logic [31:0] d;
  } qr_t;

  function automatic logic [31:0] rotl(input logic [31:0] v, input int unsigned n);
    return (v << n) | (v >> (32 - n));
  endfunction

  // one half of a quarter-round: two add, xor, rotate pairs
  function automatic qr_t qr_half(input logic [31:0] a, input logic [31:0] b,
                                  input logic [31:0] c, input logic [31:0] d,
                                  input logic second);
    qr_t r;
    logic [31:0] ta;
    logic [31:0] tb;
    logic [31:0] tc;
    logic [31:0] td;
    ta = a + b;
    td = d ^ ta;
    td = second ? rotl(td, 8) : rotl(td, 16);
    tc = c + td;
    tb = b ^ tc;
    tb = second ? rotl(tb, 7) : rotl(tb, 12);
    r.a = ta;
    r.b = tb;
    r.c = tc;
    r.d = td;
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== sv/cc20_if.sv =====
// ---------------------------------------------------------------------------
// cc20 channel interfaces
// Valid/ready channels for input words, result words and register writes
// ---------------------------------------------------------------------------
`default_nettype none

interface cc20_in_if;
  logic                          valid;
  logic                          ready;
  logic                          restart;
  logic [cc20_pkg::DataW-1:0]    data_bytes;
  logic [cc20_pkg::CountW-1:0]   byte_count;

  modport source (output valid, restart, data_bytes, byte_count, input ready);
  modport sink   (input valid, restart, data_bytes, byte_count, output ready);
endinterface

interface cc20_out_if;
  logic                          valid;
  logic                          ready;
  logic [cc20_pkg::DataW-1:0]    result_bytes;
  logic [cc20_pkg::CountW-1:0]   result_count;

  modport source (output valid, result_bytes, result_count, input ready);
  modport sink   (input valid, result_bytes, result_count, output ready);
endinterface

interface cc20_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [cc20_pkg::CfgIdxW-1:0]  reg_index;
  logic [cc20_pkg::CfgDataW-1:0] wr_data;

  modport source (output valid, reg_index, wr_data, input ready);
  modport sink   (input valid, reg_index, wr_data, output ready);
endinterface

`default_nettype wire

// ===== sv/cc20_ctrl.sv =====
// ---------------------------------------------------------------------------
// cc20_ctrl
// Sequencer for word intake, keystream xor, block generation and output
// ---------------------------------------------------------------------------
`default_nettype none

module cc20_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  input  cc20_pkg::dp_sts_t sts_i,
  output cc20_pkg::dp_cmd_t cmd_o
);
  import cc20_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_XOR,
    ST_GEN,
    ST_FIN
  } state_e;

  state_e state_q, state_d;
  logic   in_ready_q, in_ready_d;
  logic   out_valid_q, out_valid_d;
  logic   out_free;

  assign out_free = !out_valid_q || out_ready_i;

  always_comb begin
    cmd_o       = '0;
    state_d     = state_q;
    in_ready_d  = in_ready_q;
    out_valid_d = out_valid_q && !out_ready_i;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i && in_ready_q) begin
          cmd_o.accept = 1'b1;
          in_ready_d   = 1'b0;
          state_d      = ST_XOR;
        end
      end
      ST_XOR: begin
        priority if (sts_i.all_done) begin
          if (out_free) begin
            cmd_o.load_out = 1'b1;
            out_valid_d    = 1'b1;
            in_ready_d     = 1'b1;
            state_d        = ST_IDLE;
          end
        end else if (sts_i.buf_empty) begin
          cmd_o.gen_start = 1'b1;
          state_d         = ST_GEN;
        end else begin
          cmd_o.chunk = 1'b1;
        end
      end
      ST_GEN: begin
        cmd_o.gen_step = 1'b1;
        if (sts_i.last_step) begin
          state_d = ST_FIN;
        end
      end
      ST_FIN: begin
        cmd_o.gen_finish = 1'b1;
        state_d          = ST_XOR;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      in_ready_q  <= 1'b1;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      in_ready_q  <= in_ready_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_ready_o  = in_ready_q;
  assign out_valid_o = out_valid_q;

endmodule

`default_nettype wire

// ===== sv/cc20_datapath.sv =====
// ---------------------------------------------------------------------------
// cc20_datapath
// Registers, round engine, keystream buffer and byte xor for the core
// ---------------------------------------------------------------------------
`default_nettype none

module cc20_datapath #(
  parameter int unsigned BYTES_PER_ITEM = 8
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  cc20_pkg::dp_cmd_t               cmd_i,
  output cc20_pkg::dp_sts_t               sts_o,
  input  logic                            cfg_we_i,
  input  logic [cc20_pkg::CfgIdxW-1:0]    cfg_index_i,
  input  logic [cc20_pkg::CfgDataW-1:0]   cfg_data_i,
  input  logic                            in_restart_i,
  input  logic [cc20_pkg::DataW-1:0]      in_data_i,
  input  logic [cc20_pkg::CountW-1:0]     in_count_i,
  output logic [cc20_pkg::DataW-1:0]      out_bytes_o,
  output logic [cc20_pkg::CountW-1:0]     out_count_o
);
  import cc20_pkg::*;

  localparam int unsigned LaneLimit = (BYTES_PER_ITEM < NumLanes) ? BYTES_PER_ITEM : NumLanes;
  localparam logic [CountW-1:0] LaneMax = CountW'(LaneLimit);

  // configuration
  logic [63:0] key0_q, key1_q, key2_q, key3_q, nonce_lo_q;
  logic [31:0] nonce_hi_q, start_ctr_q;

  // stream state
  logic [31:0]         counter_q;
  logic [OffsetW-1:0]  offset_q;
  logic [StepW-1:0]    step_q;
  logic [31:0]         init_q [16];
  logic [31:0]         work_q [16];
  logic [31:0]         init_d [16];
  logic [31:0]         work_rnd [16];
  logic [8*BlockBytes-1:0] buf_q;
  logic [8*BlockBytes-1:0] buf_d;

  // current word
  logic [DataW-1:0]   data_q, result_q, out_bytes_q;
  logic [CountW-1:0]  count_q, done_q, out_count_q;
  logic [CountW-1:0]  count_sat, rem, take, lane_end;
  logic [OffsetW-1:0] avail;
  logic [DataW-1:0]   ks_win, ks_aligned, lane_mask;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key0_q      <= '0;
      key1_q      <= '0;
      key2_q      <= '0;
      key3_q      <= '0;
      nonce_lo_q  <= '0;
      nonce_hi_q  <= '0;
      start_ctr_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_index_i))
        CFG_KEY_PART0:     key0_q      <= cfg_data_i;
        CFG_KEY_PART1:     key1_q      <= cfg_data_i;
        CFG_KEY_PART2:     key2_q      <= cfg_data_i;
        CFG_KEY_PART3:     key3_q      <= cfg_data_i;
        CFG_NONCE_LOW:     nonce_lo_q  <= cfg_data_i;
        CFG_NONCE_HIGH:    nonce_hi_q  <= cfg_data_i[31:0];
        CFG_START_COUNTER: start_ctr_q <= cfg_data_i[31:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    init_d[0]  = Sigma[0];
    init_d[1]  = Sigma[1];
    init_d[2]  = Sigma[2];
    init_d[3]  = Sigma[3];
    init_d[4]  = key0_q[31:0];
    init_d[5]  = key0_q[63:32];
    init_d[6]  = key1_q[31:0];
    init_d[7]  = key1_q[63:32];
    init_d[8]  = key2_q[31:0];
    init_d[9]  = key2_q[63:32];
    init_d[10] = key3_q[31:0];
    init_d[11] = key3_q[63:32];
    init_d[12] = counter_q;
    init_d[13] = nonce_lo_q[31:0];
    init_d[14] = nonce_lo_q[63:32];
    init_d[15] = nonce_hi_q;
  end

  // half quarter-round on all four columns or diagonals
  always_comb begin
    qr_t r;
    logic diag;
    logic second;
    r      = '0;
    diag   = step_q[1];
    second = step_q[0];
    work_rnd = work_q;
    for (int q = 0; q < 4; q++) begin
      if (diag) begin
        r = qr_half(work_q[q], work_q[4 + ((q + 1) & 3)],
                    work_q[8 + ((q + 2) & 3)], work_q[12 + ((q + 3) & 3)], second);
        work_rnd[q]                  = r.a;
        work_rnd[4 + ((q + 1) & 3)]  = r.b;
        work_rnd[8 + ((q + 2) & 3)]  = r.c;
        work_rnd[12 + ((q + 3) & 3)] = r.d;
      end else begin
        r = qr_half(work_q[q], work_q[4 + q], work_q[8 + q], work_q[12 + q], second);
        work_rnd[q]      = r.a;
        work_rnd[4 + q]  = r.b;
        work_rnd[8 + q]  = r.c;
        work_rnd[12 + q] = r.d;
      end
    end
  end

  always_comb begin
    for (int j = 0; j < 16; j++) begin
      buf_d[32*j +: 32] = work_q[j] + init_q[j];
    end
  end

  // byte xor over the part of the word the buffer can serve
  assign count_sat  = (in_count_i > LaneMax) ? LaneMax : in_count_i;
  assign rem        = count_q - done_q;
  assign avail      = OffsetW'(BlockBytes) - offset_q;
  assign take       = (OffsetW'(rem) < avail) ? rem : avail[CountW-1:0];
  assign lane_end   = done_q + take;
  assign ks_win     = DataW'(buf_q >> {offset_q[5:0], 3'b000});
  assign ks_aligned = ks_win << {done_q[2:0], 3'b000};

  always_comb begin
    for (int i = 0; i < NumLanes; i++) begin
      lane_mask[8*i +: 8] = {8{(CountW'(i) >= done_q) && (CountW'(i) < lane_end)}};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      counter_q <= '0;
      offset_q  <= OffsetW'(BlockBytes);
      step_q    <= '0;
      count_q   <= '0;
      done_q    <= '0;
    end else begin
      if (cmd_i.accept) begin
        count_q <= count_sat;
        done_q  <= '0;
        if (in_restart_i) begin
          counter_q <= start_ctr_q;
          offset_q  <= OffsetW'(BlockBytes);
        end
      end
      if (cmd_i.chunk) begin
        done_q   <= lane_end;
        offset_q <= offset_q + OffsetW'(take);
      end
      if (cmd_i.gen_start) begin
        counter_q <= counter_q + 32'd1;
        step_q    <= '0;
      end
      if (cmd_i.gen_step) begin
        step_q <= step_q + StepW'(1);
      end
      if (cmd_i.gen_finish) begin
        offset_q <= '0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      data_q   <= in_data_i;
      result_q <= '0;
    end
    if (cmd_i.chunk) begin
      result_q <= result_q | ((data_q ^ ks_aligned) & lane_mask);
    end
    if (cmd_i.gen_start) begin
      init_q <= init_d;
      work_q <= init_d;
    end
    if (cmd_i.gen_step) begin
      work_q <= work_rnd;
    end
    if (cmd_i.gen_finish) begin
      buf_q <= buf_d;
    end
    if (cmd_i.load_out) begin
      out_bytes_q <= result_q;
      out_count_q <= count_q;
    end
  end

  assign sts_o.all_done  = (done_q == count_q);
  assign sts_o.buf_empty = offset_q[OffsetW-1];
  assign sts_o.last_step = (step_q == StepW'(LastStep));

  assign out_bytes_o = out_bytes_q;
  assign out_count_o = out_count_q;

endmodule

`default_nettype wire

// ===== sv/chacha20_stream_cipher_core.sv =====
// ---------------------------------------------------------------------------
// chacha20_stream_cipher_core
// ChaCha20 byte-stream encryption/decryption, 20 rounds, 96-bit nonce
// ---------------------------------------------------------------------------
//   channel     dir  handshake      payload
//   cfg_wr      in   valid/ready    reg_index, wr_data
//   stream_in   in   valid/ready    restart, data_bytes, byte_count
//   stream_out  out  valid/ready    result_bytes, result_count
//
// a word that crosses a block is xored in two parts around a new block; a zero-count word skips the xor
// each new 64-byte block is made in steps: load, 40 half quarter-round steps
// on the shared round engine, final add
// reset: key, nonce and counter cleared, keystream buffer marked used up
// stream_in is held while a word is in work; a waiting result blocks completion
// register writes are always taken
`default_nettype none

module chacha20_stream_cipher_core #(
  parameter int unsigned BYTES_PER_ITEM = 8
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  cc20_cfg_if.sink          cfg_wr,
  cc20_in_if.sink           stream_in,
  cc20_out_if.source        stream_out
);
  import cc20_pkg::*;

  localparam int unsigned LaneLimit = (BYTES_PER_ITEM < NumLanes) ? BYTES_PER_ITEM : NumLanes;
  localparam logic [CountW-1:0] LaneMax = CountW'(LaneLimit);

  dp_cmd_t cmd;
  dp_sts_t sts;

  assign cfg_wr.ready = 1'b1;

  cc20_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (stream_in.valid),
    .in_ready_o  (stream_in.ready),
    .out_valid_o (stream_out.valid),
    .out_ready_i (stream_out.ready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  cc20_datapath #(
    .BYTES_PER_ITEM (BYTES_PER_ITEM)
  ) u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .cfg_we_i     (cfg_wr.valid),
    .cfg_index_i  (cfg_wr.reg_index),
    .cfg_data_i   (cfg_wr.wr_data),
    .in_restart_i (stream_in.restart),
    .in_data_i    (stream_in.data_bytes),
    .in_count_i   (stream_in.byte_count),
    .out_bytes_o  (stream_out.result_bytes),
    .out_count_o  (stream_out.result_count)
  );

`ifndef SYNTHESIS
  a_one_word_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (stream_in.valid && stream_in.ready) |=> !stream_in.ready)
    else $error("input taken while a word is in work");

  a_count_limit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stream_out.valid |-> (stream_out.result_count <= LaneMax))
    else $error("result count above lane limit");

  a_unused_lanes_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stream_out.valid |->
      ((stream_out.result_bytes >> {stream_out.result_count, 3'b000}) == 64'd0))
    else $error("unused result lanes not zero");
`endif

endmodule

`default_nettype wire
